// ----- sv/sgre_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgre_pkg
// Shared types, weights and the exp2 table of the spherical Gaussian error block.
// ----------------------------------------------------------------------------
package sgre_pkg;

    // register indexes
    localparam logic [0:0] REG_LOBE_COUNT   = 1'd0;
    localparam logic [0:0] REG_SAMPLE_COUNT = 1'd1;

    // opcodes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [15:0] W_R = 16'd13933;
    localparam logic [15:0] W_G = 16'd46872;
    localparam logic [15:0] W_B = 16'd4732;
    localparam logic [47:0] OUT_MAX = {48{1'b1}};

    // 2^(-i/16) in Q16
    function automatic logic [16:0] pow2_neg(input logic [4:0] idx);
        logic [16:0] v;
        case (idx)
            5'd0:  v = 17'd65536;
            5'd1:  v = 17'd62757;
            5'd2:  v = 17'd60097;
            5'd3:  v = 17'd57549;
            5'd4:  v = 17'd55109;
            5'd5:  v = 17'd52773;
            5'd6:  v = 17'd50535;
            5'd7:  v = 17'd48393;
            5'd8:  v = 17'd46341;
            5'd9:  v = 17'd44376;
            5'd10: v = 17'd42495;
            5'd11: v = 17'd40693;
            5'd12: v = 17'd38968;
            5'd13: v = 17'd37316;
            5'd14: v = 17'd35734;
            5'd15: v = 17'd34219;
            5'd16: v = 17'd32768;
            default: v = 17'd32768;
        endcase
        return v;
    endfunction

    // sequencer states
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_LOBE = 6'b000010,
        ST_SQ   = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_ACC  = 6'b010000,
        ST_OUT  = 6'b100000
    } t_state;

endpackage

// ----- sv/sg_reconstruction_error.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sg_reconstruction_error
// Spherical Gaussian reconstruction with luminance weighted squared error.
// ----------------------------------------------------------------------------
// channel   dir  beat carries
// s_axis    in   opcode (tuser), slot, vector, sharpness, color, final_sample
// m_axis    out  error_share, running_total, set_done
// cfg       in   register index and value
//
// A load writes one lobe slot. A sample runs lobe_count lobe evaluations through
// a nine-stage pipeline fed one lobe per cycle from the lobe memory, then squares
// the three channel errors, divides the weighted sum by the sample count in a
// restoring divider, saturates the share and registers it with the running total.
// Reset is synchronous, active low, clears control and the total, and sets both registers to one.
// Input stalls while a sample is in work; the output register holds until taken.
// ----------------------------------------------------------------------------
module sg_reconstruction_error
    import sgre_pkg::*;
#(
    parameter int MAX_LOBES  = 16,
    parameter int VALUE_BITS = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // lobe_slot, vec_x, vec_y, vec_z, sharpness, color_r, color_g, color_b
    input  logic [175:0]  s_axis_tdata,
    // opcode
    input  logic [0:0]    s_axis_tuser,
    input  logic          s_axis_tlast,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // error_share, running_total
    output logic [95:0]   m_axis_tdata,
    output logic          m_axis_tlast,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [0:0]    i_cfg_index,
    input  logic [20:0]   i_cfg_data
);

    localparam int VB = VALUE_BITS;
    localparam int AW = (MAX_LOBES > 1) ? $clog2(MAX_LOBES) : 1;
    localparam int CW = $clog2(MAX_LOBES + 1);
    localparam int EW = 16 + VB + CW + 2;
    localparam logic signed [VB-1:0] VMAX = {1'b0, {(VB-1){1'b1}}};
    localparam logic signed [VB-1:0] VMIN = {1'b1, {(VB-1){1'b0}}};
    localparam logic [CW-1:0] MAXL = CW'(MAX_LOBES);

    // input fields
    logic              in_op;
    logic [3:0]        in_slot;
    logic [22:0]       in_sharp;
    logic signed [VB-1:0] in_v [6];

    function automatic logic signed [VB-1:0] sat_in(input logic [23:0] raw);
        logic signed [31:0] w;
        w = 32'(signed'(raw));
        if (w > 32'(VMAX)) return VMAX;
        if (w < 32'(VMIN)) return VMIN;
        return VB'(w);
    endfunction

    assign in_op    = s_axis_tuser[0];
    assign in_slot  = s_axis_tdata[3:0];
    assign in_sharp = s_axis_tdata[98:76];
    assign in_v[0]  = sat_in(s_axis_tdata[27:4]);
    assign in_v[1]  = sat_in(s_axis_tdata[51:28]);
    assign in_v[2]  = sat_in(s_axis_tdata[75:52]);
    assign in_v[3]  = sat_in(s_axis_tdata[122:99]);
    assign in_v[4]  = sat_in(s_axis_tdata[146:123]);
    assign in_v[5]  = sat_in(s_axis_tdata[170:147]);

    // lobe memory: axis x,y,z, lambda, amp r,g,b
    logic [7*VB-1:0] lobe_mem [MAX_LOBES];
    logic [7*VB-1:0] r_rd;

    // config registers
    logic [4:0]  r_lobe_count;
    logic [20:0] r_sample_count;
    t_state      r_state;
    logic [CW-1:0] r_iss;
    logic [CW-1:0] r_ret;
    logic [CW-1:0] r_n;
    logic signed [VB-1:0] r_s [6];
    logic        r_last;
    logic [47:0] r_sum;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready   = 1'b1;

    wire s_acc = s_axis_tvalid && s_axis_tready;
    wire m_acc = m_axis_tvalid && m_axis_tready;

    // lambda saturated to signed max
    logic [VB-1:0] in_lam;
    always_comb begin
        if (32'(in_sharp) > 32'(VMAX)) in_lam = VMAX;
        else                          in_lam = VB'(in_sharp);
    end

    // memory write and read
    always_ff @(posedge i_clk) begin
        if (s_acc && in_op == OP_LOAD && 32'(in_slot) < MAX_LOBES) begin
            lobe_mem[AW'(in_slot)] <= {in_v[5], in_v[4], in_v[3], in_lam,
                                       in_v[2], in_v[1], in_v[0]};
        end
        r_rd <= lobe_mem[r_iss[AW-1:0]];
    end

    // pipeline: p1 read valid, p2 products, p3 dot, p4 lambda*|d|, p5 *log2e,
    // p6 table interp product, p7 m>>n, p8 amp*e, p9 accumulate
    logic r_p1;
    logic r_p2, r_p3, r_p4, r_p5, r_p6, r_p7, r_p8;
    logic signed [2*VB-1:0] r_px, r_py, r_pz;
    logic signed [VB-1:0]   r_a2 [3];
    logic signed [VB-1:0]   r_a3 [3], r_a4 [3], r_a5 [3], r_a6 [3], r_a7 [3];
    logic [VB-1:0]          r_l2, r_l3;
    logic signed [2*VB+1:0] r_dot;
    logic                   r_one4, r_one5, r_one6;
    logic [55:0]            r_a4v;
    logic                   r_big5;
    logic [40:0]            r_t5;
    logic [16:0]            r_m6a;
    logic [28:0]            r_m6b;
    logic [4:0]             r_n6;
    logic                   r_z6;
    logic [16:0]            r_e7;
    logic signed [VB+17:0]  r_c8 [3];
    logic signed [EW-1:0]   r_acc [3];

    logic signed [2*VB+1:0] dsum;
    logic signed [2*VB+1:0] dq;
    logic signed [2*VB+1:0] dd;
    logic signed [2*VB+1:0] ndot;
    logic [32:0]            dmag;
    always_comb begin
        dsum = (2*VB+2)'(r_px) + (2*VB+2)'(r_py) + (2*VB+2)'(r_pz);
        dq   = dsum >>> 12;
        dd   = dq - (2*VB+2)'(4096);
        // distance magnitude, capped where any nonzero lambda already gives zero
        ndot = -r_dot;
        if (r_dot >= 0)
            dmag = '0;
        else if (ndot > (2*VB+2)'(64'h1_0000_0000))
            dmag = 33'h1_0000_0000;
        else
            dmag = 33'(ndot);
    end

    logic [43:0] a_s;
    logic [3:0]  t_idx;
    logic [11:0] t_r;
    logic [15:0] t_n;
    always_comb begin
        a_s   = r_a4v[55:12];
        t_idx = r_t5[15:12];
        t_r   = r_t5[11:0];
        t_n   = r_t5[31:16];
    end

    always_ff @(posedge i_clk) begin
        // stage 2: three products
        r_px <= (2*VB)'(r_s[0] * signed'(r_rd[VB-1:0]));
        r_py <= (2*VB)'(r_s[1] * signed'(r_rd[2*VB-1:VB]));
        r_pz <= (2*VB)'(r_s[2] * signed'(r_rd[3*VB-1:2*VB]));
        r_l2 <= r_rd[4*VB-1:3*VB];
        r_a2[0] <= signed'(r_rd[5*VB-1:4*VB]);
        r_a2[1] <= signed'(r_rd[6*VB-1:5*VB]);
        r_a2[2] <= signed'(r_rd[7*VB-1:6*VB]);
        // stage 3: dot and distance
        r_dot <= dd;
        r_l3  <= r_l2;
        for (int k = 0; k < 3; k++) r_a3[k] <= r_a2[k];
        // stage 4: lambda * |d|
        r_one4 <= (r_dot >= 0);
        r_a4v  <= 56'(r_l3) * 56'(dmag);
        for (int k = 0; k < 3; k++) r_a4[k] <= r_a3[k];
        // stage 5: times log2(e)
        r_one5 <= r_one4;
        r_big5 <= (a_s >= 44'(1 << 20));
        r_t5   <= 41'((a_s[19:0] * 37'(LOG2E_Q16)) >> 12);
        for (int k = 0; k < 3; k++) r_a5[k] <= r_a4[k];
        // stage 6: interpolation product
        r_one6 <= r_one5;
        r_m6a  <= pow2_neg({1'b0, t_idx});
        r_m6b  <= 29'((pow2_neg({1'b0, t_idx}) - pow2_neg({1'b0, t_idx} + 5'd1)) * 29'(t_r))
                  + 29'd2048;
        r_n6   <= (t_n >= 16'd32) ? 5'd31 : t_n[4:0];
        r_z6   <= (t_n >= 16'd32) || r_big5;
        for (int k = 0; k < 3; k++) r_a6[k] <= r_a5[k];
        // stage 7: exp value
        if (r_one6)     r_e7 <= 17'd65536;
        else if (r_z6)  r_e7 <= '0;
        else            r_e7 <= (r_m6a - 17'(r_m6b >> 12)) >> r_n6;
        for (int k = 0; k < 3; k++) r_a7[k] <= r_a6[k];
        // stage 8: amp * e
        for (int k = 0; k < 3; k++)
            r_c8[k] <= (VB+18)'(r_a7[k] * signed'({1'b0, r_e7}));
    end

    // pipeline valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            {r_p1, r_p2, r_p3, r_p4, r_p5, r_p6, r_p7, r_p8} <= '0;
        end else begin
            r_p1 <= (r_state == ST_LOBE) && (r_iss < r_n);
            r_p2 <= r_p1;
            r_p3 <= r_p2;
            r_p4 <= r_p3;
            r_p5 <= r_p4;
            r_p6 <= r_p5;
            r_p7 <= r_p6;
            r_p8 <= r_p7;
        end
    end

    // error squaring, one channel per cycle, each square weighted in the following cycle
    logic [1:0]  r_ch;
    logic [61:0] r_sq;
    logic [15:0] r_wd;
    logic [62:0] r_ws;
    logic signed [EW:0] errv;
    logic [EW:0]        emag;
    logic [30:0]        esat;
    logic [15:0]        wsel;
    logic [62:0]        wterm;
    always_comb begin
        errv = (EW+1)'(r_s[3'(r_ch) + 3'd3]) - (EW+1)'(r_acc[r_ch]);
        emag = errv[EW] ? (EW+1)'(-errv) : (EW+1)'(errv);
        esat = (emag > (EW+1)'(32'h7FFFFFFF)) ? 31'h7FFFFFFF : 31'(emag);
        case (r_ch)
            2'd0:    wsel = W_R;
            2'd1:    wsel = W_G;
            default: wsel = W_B;
        endcase
        wterm = 63'((r_sq >> 16) * 62'(r_wd)) + 63'(((r_sq & 62'hFFFF) * 62'(r_wd)) >> 16);
    end

    // divider
    logic [5:0]  r_dc;
    logic [62:0] r_q;
    logic [21:0] r_rem;
    logic [20:0] r_div;
    logic [22:0] rem_sh;
    always_comb rem_sh = {r_rem, r_q[62]};

    logic [47:0] r_share;
    logic [48:0] tot;
    always_comb tot = {1'b0, r_sum} + {1'b0, r_share};

    logic [47:0] r_o_share, r_o_tot;
    logic        r_o_last, r_o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_lobe_count <= 5'd1;
            r_sample_count <= 21'd1;
            r_sum <= '0;
            r_o_valid <= 1'b0;
            r_iss <= '0;
            r_ret <= '0;
        end else begin
            // config writes
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_LOBE_COUNT:   r_lobe_count <= i_cfg_data[4:0];
                    REG_SAMPLE_COUNT: r_sample_count <= i_cfg_data;
                    default: ;
                endcase
            end
            if (m_acc && r_state != ST_OUT) r_o_valid <= 1'b0;
            // accumulate returning lobes
            if (r_p8) begin
                for (int k = 0; k < 3; k++)
                    r_acc[k] <= r_acc[k] + EW'(r_c8[k] >>> 16);
                r_ret <= r_ret + 1'b1;
            end
            case (r_state)
                ST_IDLE: begin
                    if (s_acc && in_op == OP_SAMPLE) begin
                        for (int k = 0; k < 6; k++) r_s[k] <= in_v[k];
                        r_last <= s_axis_tlast;
                        r_n <= (CW'(r_lobe_count) > MAXL) ? MAXL : CW'(r_lobe_count);
                        r_iss <= '0;
                        r_ret <= '0;
                        for (int k = 0; k < 3; k++) r_acc[k] <= '0;
                        r_state <= ST_LOBE;
                    end
                end
                ST_LOBE: begin
                    if (r_iss < r_n) r_iss <= r_iss + 1'b1;
                    if (r_ret == r_n && !r_p8) begin
                        r_ch <= '0;
                        r_ws <= '0;
                        r_sq <= '0;
                        r_wd <= '0;
                        r_state <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    r_sq <= 62'(esat) * 62'(esat);
                    r_wd <= wsel;
                    r_ch <= r_ch + 2'd1;
                    // weighted add of the previous squared channel
                    r_ws <= r_ws + wterm;
                    if (r_ch == 2'd2) begin
                        r_state <= ST_DIV;
                        r_dc <= '0;
                        r_rem <= '0;
                        r_div <= (r_sample_count == '0) ? 21'd1 : r_sample_count;
                    end
                end
                ST_DIV: begin
                    // first cycle folds in the last weighted channel
                    if (r_dc == 6'd0) r_q <= r_ws + wterm;
                    r_dc <= r_dc + 6'd1;
                    if (r_dc != 6'd0) begin
                        if (rem_sh >= {2'b0, r_div}) begin
                            r_rem <= 22'(rem_sh - {2'b0, r_div});
                            r_q <= {r_q[61:0], 1'b1};
                        end else begin
                            r_rem <= rem_sh[21:0];
                            r_q <= {r_q[61:0], 1'b0};
                        end
                    end
                    if (r_dc == 6'd63) r_state <= ST_ACC;
                end
                ST_ACC: begin
                    r_share <= (r_q[62:48] != '0) ? OUT_MAX : r_q[47:0];
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (!r_o_valid || m_acc) begin
                        r_o_share <= r_share;
                        r_o_tot   <= tot[48] ? OUT_MAX : tot[47:0];
                        r_o_last  <= r_last;
                        r_o_valid <= 1'b1;
                        r_sum <= r_last ? '0 : (tot[48] ? OUT_MAX : tot[47:0]);
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {r_o_tot, r_o_share};
    assign m_axis_tlast  = r_o_last;

endmodule
